// File: rtl/dmc_pkg.sv
// Shared types, codes and the rate table of the delta-modulation sample channel.
`default_nettype none
package dmc_pkg;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] reg_index;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [6:0]  level;
        logic        dma_request;
        logic [15:0] dma_address;
        logic        sample_active;
        logic        irq_flag;
    } t_out;

    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_REG_WRITE = 3'd1;
    localparam logic [2:0] KIND_STATUS_WR = 3'd2;
    localparam logic [2:0] KIND_DMA       = 3'd3;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_LEVEL  = 2'd1;
    localparam logic [1:0] REG_ADDR   = 2'd2;
    localparam logic [1:0] REG_LENGTH = 2'd3;

    localparam int MODE_IRQ_BIT    = 7;
    localparam int MODE_LOOP_BIT   = 6;
    localparam int STATUS_EN_BIT   = 4;

    localparam logic [15:0] START_ADDR_RESET = 16'hC000;
    localparam logic [15:0] ADDR_FORCE_HIGH  = 16'h8000;
    localparam logic [6:0]  LEVEL_TOP        = 7'h7E;
    localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;
    localparam logic [7:0]  RATE_RESET       = 8'd214;

    function automatic logic [7:0] rate_lookup(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:  r = 8'd214;
            4'd1:  r = 8'd190;
            4'd2:  r = 8'd170;
            4'd3:  r = 8'd160;
            4'd4:  r = 8'd143;
            4'd5:  r = 8'd127;
            4'd6:  r = 8'd113;
            4'd7:  r = 8'd107;
            4'd8:  r = 8'd95;
            4'd9:  r = 8'd80;
            4'd10: r = 8'd71;
            4'd11: r = 8'd64;
            4'd12: r = 8'd53;
            4'd13: r = 8'd42;
            4'd14: r = 8'd36;
            default: r = 8'd27;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/dmc_in_reg.sv
// Input register stage: holds one accepted beat until the core takes it.
`default_nettype none
module dmc_in_reg
    import dmc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    input  wire logic i_advance,
    output logic      o_valid,
    output t_in       o_data
);

    logic r_valid;
    t_in  r_data;

    assign o_in_stall = r_valid && !i_advance;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_data <= i_in_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dmc_core.sv
// Channel state and its next-state logic; produces the status beat for each item.
`default_nettype none
module dmc_core
    import dmc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_in  i_item,
    output t_out      o_result
);

    logic [6:0]  r_level,     n_level;
    logic [7:0]  r_shift,     n_shift;
    logic [3:0]  r_bits_left, n_bits_left;
    logic        r_silent,    n_silent;
    logic [7:0]  r_buf,       n_buf;
    logic        r_buf_empty, n_buf_empty;
    logic [11:0] r_bytes,     n_bytes;
    logic [15:0] r_fetch,     n_fetch;
    logic [15:0] r_start,     n_start;
    logic [11:0] r_len,       n_len;
    logic [7:0]  r_period,    n_period;
    logic [7:0]  r_count,     n_count;
    logic        r_irq_en,    n_irq_en;
    logic        r_loop,      n_loop;
    logic        r_irq,       n_irq;
    logic        r_want,      n_want;

    logic [3:0]  bits_dec;
    logic [11:0] bytes_dec;
    logic [7:0]  d;

    assign d         = i_item.data_byte;
    assign bytes_dec = r_bytes - 12'd1;

    always_comb begin
        n_level     = r_level;
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_silent    = r_silent;
        n_buf       = r_buf;
        n_buf_empty = r_buf_empty;
        n_bytes     = r_bytes;
        n_fetch     = r_fetch;
        n_start     = r_start;
        n_len       = r_len;
        n_period    = r_period;
        n_count     = r_count;
        n_irq_en    = r_irq_en;
        n_loop      = r_loop;
        n_irq       = r_irq;
        n_want      = r_want;
        bits_dec    = r_bits_left - 4'd1;

        unique case (i_item.kind)
            KIND_TICK: begin
                // count of 0 or 1 both count as expiry
                if (r_count <= 8'd1) begin
                    n_count = r_period;
                    if (!r_silent) begin
                        if (r_shift[0]) begin
                            if (r_level < LEVEL_TOP) n_level = r_level + 7'd2;
                        end else if (r_level > 7'd1) begin
                            n_level = r_level - 7'd2;
                        end
                    end
                    n_shift     = {1'b0, r_shift[7:1]};
                    n_bits_left = bits_dec;
                    if (bits_dec == 4'd0) begin
                        n_bits_left = BITS_PER_BYTE;
                        n_shift     = r_buf;
                        n_silent    = r_buf_empty;
                        n_buf_empty = 1'b1;
                    end
                end else begin
                    n_count = r_count - 8'd1;
                end
                n_want = (r_bytes != 12'd0) && n_buf_empty;
            end
            KIND_REG_WRITE: begin
                unique case (i_item.reg_index)
                    REG_MODE: begin
                        n_irq_en = d[MODE_IRQ_BIT];
                        n_loop   = d[MODE_LOOP_BIT];
                        n_period = rate_lookup(d[3:0]);
                        if (!d[MODE_IRQ_BIT]) n_irq = 1'b0;
                    end
                    REG_LEVEL:  n_level = d[6:0];
                    REG_ADDR:   n_start = START_ADDR_RESET | {2'b00, d, 6'b000000};
                    REG_LENGTH: n_len   = {d, 4'b0001};
                    default:    n_len   = r_len;
                endcase
            end
            KIND_STATUS_WR: begin
                if (d[STATUS_EN_BIT]) begin
                    if (r_bytes == 12'd0) begin
                        n_bytes = r_len;
                        n_fetch = r_start;
                    end
                end else begin
                    n_bytes = 12'd0;
                    n_want  = 1'b0;
                end
                n_irq = 1'b0;
            end
            KIND_DMA: begin
                // stray return with nothing left is dropped
                if (r_bytes != 12'd0) begin
                    n_buf       = d;
                    n_buf_empty = 1'b0;
                    n_want      = 1'b0;
                    n_fetch     = (r_fetch + 16'd1) | ADDR_FORCE_HIGH;
                    n_bytes     = bytes_dec;
                    if (bytes_dec == 12'd0) begin
                        if (r_loop) begin
                            n_bytes = r_len;
                            n_fetch = r_start;
                        end else if (r_irq_en) begin
                            n_irq = 1'b1;
                        end
                    end
                end
            end
            default: n_want = r_want;
        endcase
    end

    always_comb begin
        o_result.level         = n_level;
        o_result.dma_request   = n_want;
        o_result.dma_address   = n_fetch;
        o_result.sample_active = n_bytes != 12'd0;
        o_result.irq_flag      = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= 7'd0;
            r_shift     <= 8'd0;
            r_bits_left <= BITS_PER_BYTE;
            r_silent    <= 1'b1;
            r_buf       <= 8'd0;
            r_buf_empty <= 1'b1;
            r_bytes     <= 12'd0;
            r_fetch     <= 16'd0;
            r_start     <= START_ADDR_RESET;
            r_len       <= 12'd1;
            r_period    <= RATE_RESET;
            r_count     <= 8'd0;
            r_irq_en    <= 1'b0;
            r_loop      <= 1'b0;
            r_irq       <= 1'b0;
            r_want      <= 1'b0;
        end else if (i_fire) begin
            r_level     <= n_level;
            r_shift     <= n_shift;
            r_bits_left <= n_bits_left;
            r_silent    <= n_silent;
            r_buf       <= n_buf;
            r_buf_empty <= n_buf_empty;
            r_bytes     <= n_bytes;
            r_fetch     <= n_fetch;
            r_start     <= n_start;
            r_len       <= n_len;
            r_period    <= n_period;
            r_count     <= n_count;
            r_irq_en    <= n_irq_en;
            r_loop      <= n_loop;
            r_irq       <= n_irq;
            r_want      <= n_want;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dmc_out_reg.sv
// Result register: holds the status beat until downstream takes it.
`default_nettype none
module dmc_out_reg
    import dmc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  wire t_out i_result,
    input  wire logic i_out_stall,
    output logic      o_out_valid,
    output t_out      o_out_data,
    output logic      o_free
);

    logic r_valid;
    t_out r_data;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_result;
        end
    end

endmodule
`default_nettype wire

// File: rtl/delta_modulation_sample_channel_top.sv
// Path: an accepted input beat is held in the input register; its result beat is then
// captured in the result register, which drives the output.
// Throughput: one item per cycle while downstream does not stall; the core updates its state per item.
// Downstream stall backs up through the result and input registers, no beat lost.
// Reset: synchronous active-low; channel state returns to its power-up values
// and both pipeline registers empty.
`default_nettype none
module delta_modulation_sample_channel_top
    import dmc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    logic advance;
    logic item_valid;
    t_in  item;
    t_out result;
    logic fire;

    assign fire = item_valid && advance;

    dmc_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_advance  (advance),
        .o_valid    (item_valid),
        .o_data     (item)
    );

    dmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (item),
        .o_result (result)
    );

    dmc_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (item_valid),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_free      (advance)
    );

endmodule
`default_nettype wire
